@@ rtl/core/sve_pkg.sv @@
// package for the smoothed velocity estimator
// shared widths, reset constants, controller states and command/status structs
package sve_pkg;

   localparam int POS_W = 32;
   localparam int TIME_W = 24;
   localparam int CFG_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int DEF_POS_FRAC_BITS = 8;
   localparam int DEF_TIME_FRAC_BITS = 16;
   localparam logic [CFG_W-1:0] MIN_FRAME_RESET = 16'd66;
   localparam logic [CFG_W-1:0] RATE_RESET = 16'd1536;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FRAME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAIN,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL,
      ST_ACC,
      ST_NEXT_AXIS,
      ST_SQRT_START,
      ST_SQRT_WAIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic gain;
      logic div_start;
      logic mul;
      logic acc;
      logic next_axis;
      logic sqrt_start;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic update;
      logic div_done;
      logic sqrt_done;
      logic last_axis;
   } status_type;

endpackage

@@ rtl/core/sve_datapath.sv @@
// datapath: sample registers, shared serial divider, multiplier step, serial root
// depends on sve_pkg; driven by sve_ctrl commands
module sve_datapath import sve_pkg::*; #(
   parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [3*POS_W+TIME_W-1:0] req_payload,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_idx,
   input  logic [CFG_W-1:0]        csr_data,
   output logic [4*POS_W-1:0]      result,
   output logic                    result_updated
);
   localparam int GAIN_FB = TIME_FRAC_BITS + 8;
   localparam int GW = GAIN_FB + 1;
   localparam int NUM_W = 33 + TIME_FRAC_BITS;
   localparam int NCNT_W = $clog2(NUM_W + 1);
   localparam int SQ_W = 66;
   localparam int SCNT_W = 6;

   logic [CFG_W-1:0] min_ff, rate_ff;
   logic signed [POS_W-1:0] lastp_ff [3];
   logic signed [POS_W-1:0] vel_ff [3];
   logic [POS_W-1:0] speed_ff;
   logic signed [POS_W-1:0] newp_ff [3];
   logic [TIME_W-1:0] t_ff;
   logic [GW-1:0] gain_ff;
   logic [1:0] axis_ff;
   logic upd_ff;

   // divider
   logic [NUM_W-1:0] quo_ff;
   logic [TIME_W:0] rem_ff;
   logic [NCNT_W-1:0] dcnt_ff;
   logic dbusy_ff, dneg_ff;
   logic signed [POS_W+GW+1:0] prod_ff;
   logic [SQ_W-1:0] sum_ff;

   // root
   logic [SQ_W-1:0] sv_ff, sres_ff, sbit_ff;
   logic [SCNT_W-1:0] scnt_ff;
   logic sbusy_ff;

   logic signed [POS_W:0] delta;
   logic [POS_W:0] dmag;
   logic [NUM_W-1:0] num;
   logic [TIME_W+CFG_W-1:0] graw;
   logic [TIME_W:0] rem_sh;
   logic signed [POS_W+1:0] raw, diff;
   logic signed [POS_W+1:0] sum_v;
   logic signed [POS_W+GW+1:0] shifted;
   logic signed [POS_W-1:0] vnew;
   logic [POS_W-1:0] vabs;
   logic [2*POS_W-1:0] vsq;
   logic [SQ_W-1:0] strial;
   logic [POS_W-1:0] spd_now;

   always_comb begin
      delta = {newp_ff[axis_ff][POS_W-1], newp_ff[axis_ff]}
            - {lastp_ff[axis_ff][POS_W-1], lastp_ff[axis_ff]};
      dmag = delta[POS_W] ? (POS_W+1)'(0) - delta : delta;
      num = NUM_W'(dmag) << TIME_FRAC_BITS;
      graw = t_ff * rate_ff;
      rem_sh = {rem_ff[TIME_W-1:0], quo_ff[NUM_W-1]};
      if (quo_ff > NUM_W'(33'h80000000))
         raw = dneg_ff ? -(POS_W+2)'(33'sh80000000) : (POS_W+2)'(33'sh7FFFFFFF);
      else if (dneg_ff)
         raw = -$signed({1'b0, quo_ff[POS_W:0]});
      else
         raw = (quo_ff[POS_W-1:0] == 32'h80000000) ? (POS_W+2)'(33'sh7FFFFFFF)
             : $signed({2'b0, quo_ff[POS_W-1:0]});
      diff = raw - (POS_W+2)'(vel_ff[axis_ff]);
      shifted = prod_ff >>> GAIN_FB;
      sum_v = (POS_W+2)'(vel_ff[axis_ff]) + shifted[POS_W+1:0];
      if (sum_v > (POS_W+2)'(33'sh7FFFFFFF)) vnew = 32'sh7FFFFFFF;
      else if (sum_v < -(POS_W+2)'(33'sh80000000)) vnew = 32'sh80000000;
      else vnew = sum_v[POS_W-1:0];
      vabs = vnew[POS_W-1] ? POS_W'(0) - vnew : vnew;
      vsq = vabs * vabs;
      strial = sres_ff + sbit_ff;
      if (!upd_ff) spd_now = speed_ff;
      else if (sres_ff[SQ_W-1:POS_W] != '0) spd_now = '1;
      else spd_now = sres_ff[POS_W-1:0];
      status.update = t_ff > TIME_W'(min_ff);
      status.div_done = !dbusy_ff;
      status.sqrt_done = !sbusy_ff;
      status.last_axis = axis_ff == 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_FRAME_RESET;
         rate_ff <= RATE_RESET;
         speed_ff <= '0;
         dbusy_ff <= 1'b0;
         sbusy_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            lastp_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_idx == CSR_MIN_FRAME) min_ff <= csr_data;
            else rate_ff <= csr_data;
         end
         if (cmd.load) begin
            for (int i = 0; i < 3; i++)
               newp_ff[i] <= req_payload[i*POS_W +: POS_W];
            t_ff <= req_payload[3*POS_W +: TIME_W];
            axis_ff <= '0;
            sum_ff <= '0;
            upd_ff <= 1'b0;
         end
         if (cmd.gain)
            gain_ff <= (graw > (TIME_W+CFG_W)'(1 << GAIN_FB)) ? GW'(1 << GAIN_FB)
                     : GW'(graw);
         if (cmd.div_start) begin
            quo_ff <= num;
            rem_ff <= '0;
            dneg_ff <= delta[POS_W];
            dcnt_ff <= NCNT_W'(NUM_W);
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff) begin
            if (rem_sh >= {1'b0, t_ff}) begin
               rem_ff <= rem_sh - {1'b0, t_ff};
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff - 1'b1;
            if (dcnt_ff == NCNT_W'(1)) dbusy_ff <= 1'b0;
         end
         if (cmd.mul)
            prod_ff <= diff * $signed({1'b0, gain_ff});
         if (cmd.acc) begin
            vel_ff[axis_ff] <= vnew;
            sum_ff <= sum_ff + SQ_W'(vsq);
            upd_ff <= 1'b1;
         end
         if (cmd.next_axis) axis_ff <= axis_ff + 1'b1;
         if (cmd.sqrt_start) begin
            sv_ff <= sum_ff;
            sres_ff <= '0;
            sbit_ff <= SQ_W'(1) << (SQ_W - 2);
            scnt_ff <= SCNT_W'(SQ_W / 2);
            sbusy_ff <= 1'b1;
         end else if (sbusy_ff) begin
            if (sv_ff >= strial) begin
               sv_ff <= sv_ff - strial;
               sres_ff <= (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_ff <= sres_ff >> 1;
            end
            sbit_ff <= sbit_ff >> 2;
            scnt_ff <= scnt_ff - 1'b1;
            if (scnt_ff == SCNT_W'(1)) sbusy_ff <= 1'b0;
         end
         if (cmd.finish) begin
            speed_ff <= spd_now;
            for (int i = 0; i < 3; i++) lastp_ff[i] <= newp_ff[i];
         end
      end
   end

   assign result = {spd_now, vel_ff[2], vel_ff[1], vel_ff[0]};
   assign result_updated = upd_ff;
endmodule

@@ rtl/core/sve_ctrl.sv @@
// controller state machine for the smoothed velocity estimator
// depends on sve_pkg; commands sve_datapath
module sve_ctrl import sve_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  logic       rsp_free,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       done
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_fire) state_in = ST_GAIN;
         ST_GAIN:       state_in = status.update ? ST_DIV_START : ST_OUT;
         ST_DIV_START:  state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:   if (status.div_done) state_in = ST_MUL;
         ST_MUL:        state_in = ST_ACC;
         ST_ACC:        state_in = status.last_axis ? ST_SQRT_START : ST_NEXT_AXIS;
         ST_NEXT_AXIS:  state_in = ST_DIV_START;
         ST_SQRT_START: state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT:  if (status.sqrt_done) state_in = ST_OUT;
         ST_OUT:        if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load = req_fire;
      busy = state_ff != ST_IDLE;
      done = 1'b0;
      unique case (state_ff)
         ST_GAIN:       cmd.gain = 1'b1;
         ST_DIV_START:  cmd.div_start = 1'b1;
         ST_MUL:        cmd.mul = 1'b1;
         ST_ACC:        cmd.acc = 1'b1;
         ST_NEXT_AXIS:  cmd.next_axis = 1'b1;
         ST_SQRT_START: cmd.sqrt_start = 1'b1;
         ST_OUT: begin
            cmd.finish = rsp_free;
            done = rsp_free;
         end
         default: ;
      endcase
   end
endmodule

@@ rtl/core/smoothed_velocity_estimator.sv @@
// channel | dir | tdata fields (low bit up)                     | tuser
// req     | in  | pos_x, pos_y, pos_z, elapsed_time             | -
// rsp     | out | vel_x, vel_y, vel_z, speed                    | updated
// csr     | in  | index 0 min_frame_time, index 1 smoothing_rate | -
// updating sample: gain, then per axis divide (start, serial steps, done), multiply,
// accumulate and an axis step between axes, then root and output; a held sample goes
// from gain straight to output; reset clears state, velocity and speed, resets registers
// a new sample is accepted only while the controller is idle; a finished result waits
// in the output state while rsp still holds an untaken transaction
module smoothed_velocity_estimator import sve_pkg::*; #(
   parameter int TIME_FRAC_BITS = DEF_TIME_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [127:0]         req_tdata,   // pos_x, pos_y, pos_z, elapsed_time, zero pad
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [127:0]         rsp_tdata,   // vel_x, vel_y, vel_z, speed
   output logic                 rsp_tuser,   // updated
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);
   cmd_type cmd;
   status_type status;
   logic busy, done;
   logic [4*POS_W-1:0] result;
   logic result_updated;
   logic rsp_free;

   assign rsp_free = !rsp_tvalid || rsp_tready;
   assign req_tready = !busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (done) rsp_tvalid <= 1'b1;
      else if (rsp_tready) rsp_tvalid <= 1'b0;
      if (done) begin
         rsp_tdata <= result;
         rsp_tuser <= result_updated;
      end
   end

   sve_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_fire(req_tvalid && req_tready),
      .rsp_free(rsp_free), .status(status), .cmd(cmd), .busy(busy), .done(done)
   );

   sve_datapath #(.TIME_FRAC_BITS(TIME_FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_payload(req_tdata[3*POS_W+TIME_W-1:0]),
      .csr_we(csr_valid && csr_ready), .csr_idx(csr_index), .csr_data(csr_data),
      .result(result), .result_updated(result_updated)
   );
endmodule

@@ tb/sv/tb_smoothed_velocity_estimator.sv @@
// testbench for smoothed_velocity_estimator: streams position samples with random gaps
// and stalls, predicts each smoothed velocity and speed in a behavioral model and checks
// rsp transactions in order; depends on sve_pkg and the dut only
`timescale 1ns / 100ps

module tb_smoothed_velocity_estimator;
   import sve_pkg::*;

   localparam int TFB = DEF_TIME_FRAC_BITS;
   localparam int GFB = TFB + 8;
   localparam longint CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 400;

   typedef struct packed {
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [31:0]        spd;
      logic               upd;
   } vel_result_type;

   typedef struct {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic [23:0]        et;
      bit                 known;
      vel_result_type     res;
   } sample_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   smoothed_velocity_estimator dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [15:0] min_time_reg;
   logic [15:0] rate_reg;
   logic signed [31:0] prev_pos [3];
   logic signed [31:0] smooth_vel [3];
   logic [31:0] held_speed;

   vel_result_type velocity_queue[$];
   int mismatches = 0;
   longint cycles = 0;
   bit hold_off_active = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic vel_result_type predict_velocity(logic signed [31:0] px,
         logic signed [31:0] py, logic signed [31:0] pz, logic [23:0] et);
      vel_result_type r;
      logic signed [31:0] p [3];
      longint delta, raw, diff, prod, sh;
      logic [63:0] mag, q, g, av, sum;
      p[0] = px; p[1] = py; p[2] = pz;
      r.upd = 0;
      if (et > min_time_reg) begin
         g = 64'(et) * 64'(rate_reg);
         if (g > (64'd1 << GFB)) g = 64'd1 << GFB;
         sum = 0;
         for (int i = 0; i < 3; i++) begin
            delta = longint'(p[i]) - longint'(prev_pos[i]);
            mag = (delta < 0) ? -delta : delta;
            q = (mag << TFB) / et;
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            raw = (delta < 0) ? -longint'(q) : longint'(q);
            raw = clamp32(raw);
            diff = raw - longint'(smooth_vel[i]);
            prod = diff * longint'(g);
            sh = prod >>> GFB;
            smooth_vel[i] = 32'(clamp32(longint'(smooth_vel[i]) + sh));
            av = (smooth_vel[i] < 0) ? -longint'(smooth_vel[i]) : longint'(smooth_vel[i]);
            sum = sum + av * av;
         end
         av = root_floor(sum);
         held_speed = (av > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : av[31:0];
         r.upd = 1;
      end
      for (int i = 0; i < 3; i++) prev_pos[i] = p[i];
      r.vx = smooth_vel[0];
      r.vy = smooth_vel[1];
      r.vz = smooth_vel[2];
      r.spd = held_speed;
      return r;
   endfunction

   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MIN_FRAME) min_time_reg = val;
      else rate_reg = val;
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (velocity_queue.size() != 0) @(posedge clock);
      wait_cycles(SETTLE_CYCLES);
   endtask

   task automatic send_sample(logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic [23:0] et, bit known, vel_result_type exp_res,
         bit allow_gap);
      vel_result_type pred;
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         wait_cycles(($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                 : $urandom_range(1, 4));
      end
      req_tvalid <= 1;
      req_tdata <= {8'h00, et, pz, py, px};
      do @(posedge clock); while (!req_tready);
      pred = predict_velocity(px, py, pz, et);
      if (known && pred != exp_res) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with predictor: table %h model %h", exp_res, pred);
      end
      velocity_queue.push_back(pred);
   endtask

   // random position: mostly small moves around the previous position, some extremes
   function automatic logic signed [31:0] pick_pos(logic signed [31:0] last);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2, 3: return last + $signed(32'($urandom_range(0, 2000000)) - 32'sd1000000);
         default: return last + $signed(32'($urandom_range(0, 4000)) - 32'sd2000);
      endcase
   endfunction

   function automatic logic [23:0] pick_time();
      case ($urandom_range(0, 9))
         0: return 24'($urandom_range(0, 70));
         1: return 24'($urandom);
         2: return $urandom_range(0, 1) ? 24'hFF_FFFF : 24'd1;
         default: return 24'($urandom_range(200, 8000));
      endcase
   endfunction

   // receiver
   initial begin
      vel_result_type got, want;
      int stall;
      stall = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.vx = rsp_tdata[31:0];
            got.vy = rsp_tdata[63:32];
            got.vz = rsp_tdata[95:64];
            got.spd = rsp_tdata[127:96];
            got.upd = rsp_tuser;
            if (velocity_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp transaction %h", got);
            end else begin
               want = velocity_queue.pop_front();
               if (got != want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"rsp mismatch: expected vx %0d vy %0d vz %0d spd %0d upd %0b,",
                        " got vx %0d vy %0d vz %0d spd %0d upd %0b"},
                        want.vx, want.vy, want.vz, want.spd, want.upd,
                        got.vx, got.vy, got.vz, got.spd, got.upd);
               end
            end
         end
         if (hold_off_active) rsp_tready <= 0;
         else if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 99) == 0) begin
            stall = $urandom_range(20, 200);
            rsp_tready <= 0;
         end else if ($urandom_range(0, 3) == 0)
            rsp_tready <= 0;
         else rsp_tready <= 1;
      end
   end

   // long receiver hold-off, counted in cycles
   initial begin
      wait (!reset);
      wait_cycles(3000);
      hold_off_active = 1;
      wait_cycles(3000);
      hold_off_active = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_smoothed_velocity_estimator: errors");
         $finish;
      end
   end

   sample_row_type directed_rows[$];

   function automatic sample_row_type row(logic signed [31:0] px, logic signed [31:0] py,
         logic signed [31:0] pz, logic [23:0] et, bit known, vel_result_type r);
      sample_row_type s;
      s.px = px; s.py = py; s.pz = pz; s.et = et; s.known = known; s.res = r;
      return s;
   endfunction

   initial begin
      vel_result_type none;
      logic signed [31:0] lx, ly, lz;
      int n;
      none = '0;
      min_time_reg = MIN_FRAME_RESET;
      rate_reg = RATE_RESET;
      for (int i = 0; i < 3; i++) begin
         prev_pos[i] = 0;
         smooth_vel[i] = 0;
      end
      held_speed = 0;
      wait_cycles(11);
      reset <= 0;
      @(posedge clock);

      // directed table: held samples after reset are all zero
      directed_rows.push_back(row(0, 0, 0, 24'd0, 1'b1, none));
      directed_rows.push_back(row(100, -100, 5, 24'd66, 1'b1, none));
      directed_rows.push_back(row(0, 0, 0, 24'd67, 1'b0, none));
      directed_rows.push_back(row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 24'd1, 1'b0, none));
      directed_rows.push_back(row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
         24'd67, 1'b0, none));
      directed_rows.push_back(row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
         24'hFF_FFFF, 1'b0, none));
      directed_rows.push_back(row(256, 512, -768, 24'd65536, 1'b0, none));
      directed_rows.push_back(row(-1, -1, -1, 24'd1000, 1'b0, none));
      directed_rows.push_back(row(-1, -1, -1, 24'd1000, 1'b0, none));
      directed_rows.push_back(row(1000, 2000, 3000, 24'd0, 1'b0, none));
      directed_rows.push_back(row(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
         24'h80_0000, 1'b0, none));
      foreach (directed_rows[i])
         send_sample(directed_rows[i].px, directed_rows[i].py, directed_rows[i].pz,
            directed_rows[i].et, directed_rows[i].known, directed_rows[i].res, 0);

      // register phases, extremes included
      for (int phase = 0; phase < 6; phase++) begin
         wait_drained();
         case (phase)
            0: begin write_csr(CSR_MIN_FRAME, 16'd0); write_csr(CSR_RATE, 16'hFFFF); end
            1: begin write_csr(CSR_MIN_FRAME, 16'hFFFF); write_csr(CSR_RATE, 16'd0); end
            2: begin write_csr(CSR_MIN_FRAME, MIN_FRAME_RESET);
                      write_csr(CSR_RATE, RATE_RESET); end
            3: begin write_csr(CSR_MIN_FRAME, 16'($urandom));
                      write_csr(CSR_RATE, 16'($urandom)); end
            4: begin write_csr(CSR_MIN_FRAME, 16'($urandom_range(0, 300)));
                      write_csr(CSR_RATE, 16'($urandom_range(1, 4000))); end
            default: begin write_csr(CSR_MIN_FRAME, 16'd66); write_csr(CSR_RATE, 16'd256); end
         endcase
         csr_valid <= 0;
         n = (phase == 2) ? 900 : 220;
         for (int k = 0; k < n; k++) begin
            lx = pick_pos(prev_pos[0]);
            ly = pick_pos(prev_pos[1]);
            lz = pick_pos(prev_pos[2]);
            send_sample(lx, ly, lz, pick_time(), 0, none, (phase != 2) || (k > 400));
         end
      end

      wait_drained();
      if (mismatches == 0) $display("tb_smoothed_velocity_estimator: clean");
      else $display("tb_smoothed_velocity_estimator: errors");
      $finish;
   end

endmodule
